// ----- sv/dsts_pkg.sv -----
// dsts_pkg: shared constants, types and helpers for the decimal triple subtract unit.
// No dependencies; every other file refers to it by scoped names.
package dsts_pkg;

   localparam int DIGITS = 64;
   localparam int ADDR_W = $clog2(DIGITS);
   localparam int CNT_W  = ADDR_W + 1;

   localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(DIGITS);
   localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);
   localparam logic [CNT_W-1:0]  POS_LAST  = CNT_W'(DIGITS - 1);
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DIGITS - 1);

   localparam logic [3:0] DIGIT_MAX = 4'd9;
   localparam logic [3:0] RADIX     = 4'd10;

   typedef enum logic [1:0] {
      CMD_X    = 2'd0,
      CMD_Y    = 2'd1,
      CMD_Z    = 2'd2,
      CMD_CALC = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PASS_A,
      ST_PASS_B,
      ST_PASS_C,
      ST_EMIT_RD,
      ST_EMIT_CHK,
      ST_SHOW
   } state_type;

   typedef struct packed {
      logic              push;
      logic              clear;
      logic [ADDR_W-1:0] rd_pos;
   } store_ctl_type;

   typedef struct packed {
      logic step;
      logic first;
   } alu_ctl_type;

   function automatic logic [3:0] clamp_digit(input logic [3:0] d);
      return (d > DIGIT_MAX) ? DIGIT_MAX : d;
   endfunction

endpackage

// ----- sv/decimal_signed_triple_subtract_unit.sv -----
// decimal_signed_triple_subtract_unit: top level, sequencer, result memory and output register.
// Depends on dsts_pkg, dsts_digit_store and dsts_bcd_alu.
//
//   channel   direction  tdata               tuser          tlast
//   req_      in         [3:0] digit         [1:0] cmd      -
//   rsp_      out        [3:0] digit_res     [0] negative   last
//
// A digit request (cmd 0..2) is stored when it is accepted. A compute request runs two or three
// passes over all DIGITS positions through the one-digit BCD subtractor, then reads the result
// memory from the top, through EMIT_RD and EMIT_CHK for each suppressed leading zero and
// through EMIT_RD, EMIT_CHK and SHOW for each emitted digit; SHOW holds while rsp_ stalls.
// Stores are emptied by clearing their fill counts; no clearing pass after reset.
// req_tready is low during reset and from a compute request until its last result is taken.
module decimal_signed_triple_subtract_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [3:0] digit, [7:4] zero
   input  logic [1:0] req_tuser,   // [1:0] cmd
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [3:0] digit_res, [7:4] zero
   output logic       rsp_tuser,   // [0] negative
   output logic       rsp_tlast
);

   dsts_pkg::state_type state_ff;
   dsts_pkg::state_type state_in;

   logic [dsts_pkg::CNT_W-1:0]  i_ff;
   logic [dsts_pkg::CNT_W-1:0]  i_in;
   logic [dsts_pkg::ADDR_W-1:0] e_ff;
   logic [dsts_pkg::ADDR_W-1:0] e_in;
   logic                        lead_ff;
   logic                        lead_in;
   logic                        borrow_a_ff;
   logic                        borrow_a_in;
   logic                        neg_ff;
   logic                        neg_in;
   logic [3:0]                  out_digit_ff;
   logic [3:0]                  out_digit_in;
   logic                        out_last_ff;
   logic                        out_last_in;

   logic [3:0]                  t_mem [dsts_pkg::DIGITS];
   logic [3:0]                  t_q_ff;
   logic                        t_we;
   logic [dsts_pkg::ADDR_W-1:0] t_wr_addr;
   logic [dsts_pkg::ADDR_W-1:0] t_rd_addr;

   dsts_pkg::store_ctl_type     x_ctl;
   dsts_pkg::store_ctl_type     y_ctl;
   dsts_pkg::store_ctl_type     z_ctl;
   dsts_pkg::alu_ctl_type       alu_ctl;
   logic [3:0]                  x_digit;
   logic [3:0]                  y_digit;
   logic [3:0]                  z_digit;
   logic [3:0]                  opa;
   logic [3:0]                  opb;
   logic [3:0]                  alu_diff;
   logic                        alu_bout;

   dsts_pkg::cmd_type           cmd;
   logic [3:0]                  in_digit;
   logic                        req_accept;
   logic                        in_pass;
   logic                        proc;
   logic                        clear_all;
   logic [dsts_pkg::ADDR_W-1:0] rd_pos;
   logic [dsts_pkg::CNT_W-1:0]  wr_pos;

   assign cmd        = dsts_pkg::cmd_type'(req_tuser);
   assign in_digit   = dsts_pkg::clamp_digit(req_tdata[3:0]);
   assign req_tready = (state_ff == dsts_pkg::ST_IDLE) && !reset;
   assign req_accept = req_tvalid && req_tready;

   dsts_digit_store u_x_store (
      .clock      (clock),
      .reset      (reset),
      .ctl        (x_ctl),
      .push_digit (in_digit),
      .rd_digit   (x_digit)
   );

   dsts_digit_store u_y_store (
      .clock      (clock),
      .reset      (reset),
      .ctl        (y_ctl),
      .push_digit (in_digit),
      .rd_digit   (y_digit)
   );

   dsts_digit_store u_z_store (
      .clock      (clock),
      .reset      (reset),
      .ctl        (z_ctl),
      .push_digit (in_digit),
      .rd_digit   (z_digit)
   );

   dsts_bcd_alu u_alu (
      .clock (clock),
      .reset (reset),
      .ctl   (alu_ctl),
      .opa   (opa),
      .opb   (opb),
      .diff  (alu_diff),
      .bout  (alu_bout)
   );

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      e_in         = e_ff;
      lead_in      = lead_ff;
      borrow_a_in  = borrow_a_ff;
      neg_in       = neg_ff;
      out_digit_in = out_digit_ff;
      out_last_in  = out_last_ff;
      clear_all    = 1'b0;
      opa          = 4'd0;
      opb          = 4'd0;

      in_pass = (state_ff == dsts_pkg::ST_PASS_A) || (state_ff == dsts_pkg::ST_PASS_B) ||
                (state_ff == dsts_pkg::ST_PASS_C);
      // issue reads for digit i while the digit read last cycle is processed
      proc    = (i_ff != '0);
      rd_pos  = (i_ff < dsts_pkg::CNT_FULL) ? i_ff[dsts_pkg::ADDR_W-1:0] : '0;
      wr_pos  = i_ff - 1'b1;

      case (state_ff)
         dsts_pkg::ST_IDLE: begin
            if (req_accept && (cmd == dsts_pkg::CMD_CALC)) begin
               state_in = dsts_pkg::ST_PASS_A;
            end
         end
         dsts_pkg::ST_PASS_A: begin
            // T = x - y
            opa = x_digit;
            opb = y_digit;
            if (i_ff == dsts_pkg::CNT_FULL) begin
               borrow_a_in = alu_bout;
               state_in    = dsts_pkg::ST_PASS_B;
            end
         end
         dsts_pkg::ST_PASS_B: begin
            // x >= y: T = T - z;  x < y: T = z - T, which is (y - x) + z mod 10^N
            if (borrow_a_ff) begin
               opa = z_digit;
               opb = t_q_ff;
            end else begin
               opa = t_q_ff;
               opb = z_digit;
            end
            if (i_ff == dsts_pkg::CNT_FULL) begin
               if (borrow_a_ff) begin
                  neg_in   = 1'b1;
                  state_in = dsts_pkg::ST_EMIT_RD;
               end else if (alu_bout) begin
                  neg_in   = 1'b1;
                  state_in = dsts_pkg::ST_PASS_C;
               end else begin
                  neg_in   = 1'b0;
                  state_in = dsts_pkg::ST_EMIT_RD;
               end
            end
         end
         dsts_pkg::ST_PASS_C: begin
            // ten's complement: T = 0 - T
            opa = 4'd0;
            opb = t_q_ff;
            if (i_ff == dsts_pkg::CNT_FULL) begin
               state_in = dsts_pkg::ST_EMIT_RD;
            end
         end
         dsts_pkg::ST_EMIT_RD: begin
            state_in = dsts_pkg::ST_EMIT_CHK;
         end
         dsts_pkg::ST_EMIT_CHK: begin
            if (lead_ff && (t_q_ff == 4'd0) && (e_ff != '0)) begin
               e_in     = e_ff - 1'b1;
               state_in = dsts_pkg::ST_EMIT_RD;
            end else begin
               out_digit_in = t_q_ff;
               out_last_in  = (e_ff == '0);
               lead_in      = 1'b0;
               state_in     = dsts_pkg::ST_SHOW;
            end
         end
         dsts_pkg::ST_SHOW: begin
            if (rsp_tready) begin
               if (out_last_ff) begin
                  state_in = dsts_pkg::ST_IDLE;
               end else begin
                  e_in     = e_ff - 1'b1;
                  state_in = dsts_pkg::ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = dsts_pkg::ST_IDLE;
         end
      endcase

      if (in_pass) begin
         if (i_ff == dsts_pkg::CNT_FULL) begin
            i_in = '0;
         end else begin
            i_in = i_ff + 1'b1;
         end
      end

      // entering the output phase: result lives in T, so the stores can go
      if (in_pass && (state_in == dsts_pkg::ST_EMIT_RD)) begin
         e_in      = dsts_pkg::ADDR_LAST;
         lead_in   = 1'b1;
         clear_all = 1'b1;
      end

      x_ctl.push   = req_accept && (cmd == dsts_pkg::CMD_X);
      x_ctl.clear  = clear_all;
      x_ctl.rd_pos = rd_pos;
      y_ctl.push   = req_accept && (cmd == dsts_pkg::CMD_Y);
      y_ctl.clear  = clear_all;
      y_ctl.rd_pos = rd_pos;
      z_ctl.push   = req_accept && (cmd == dsts_pkg::CMD_Z);
      z_ctl.clear  = clear_all;
      z_ctl.rd_pos = rd_pos;

      alu_ctl.step  = in_pass && proc;
      alu_ctl.first = (i_ff == dsts_pkg::CNT_ONE);

      t_we      = in_pass && proc;
      t_wr_addr = wr_pos[dsts_pkg::ADDR_W-1:0];
      t_rd_addr = in_pass ? rd_pos : e_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= dsts_pkg::ST_IDLE;
         i_ff        <= '0;
         e_ff        <= '0;
         lead_ff     <= 1'b0;
         borrow_a_ff <= 1'b0;
         neg_ff      <= 1'b0;
         out_last_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         i_ff        <= i_in;
         e_ff        <= e_in;
         lead_ff     <= lead_in;
         borrow_a_ff <= borrow_a_in;
         neg_ff      <= neg_in;
         out_last_ff <= out_last_in;
      end
   end

   always_ff @(posedge clock) begin
      out_digit_ff <= out_digit_in;
      if (t_we) begin
         t_mem[t_wr_addr] <= alu_diff;
      end
      t_q_ff <= t_mem[t_rd_addr];
   end

   assign rsp_tvalid = (state_ff == dsts_pkg::ST_SHOW);
   assign rsp_tdata  = {4'd0, out_digit_ff};
   assign rsp_tuser  = neg_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ----- sv/dsts_bcd_alu.sv -----
// dsts_bcd_alu: shared one-digit BCD subtractor with its borrow register.
// Depends on dsts_pkg.
module dsts_bcd_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  dsts_pkg::alu_ctl_type ctl,
   input  logic [3:0]           opa,
   input  logic [3:0]           opb,
   output logic [3:0]           diff,
   output logic                 bout
);

   logic       borrow_ff;
   logic       borrow_in;
   logic       bin;
   logic [4:0] raw;

   always_comb begin
      bin       = ctl.first ? 1'b0 : borrow_ff;
      raw       = {1'b0, opa} - {1'b0, opb} - {4'd0, bin};
      bout      = raw[4];
      // negative partial difference wraps back into 0..9
      diff      = raw[4] ? (raw[3:0] + dsts_pkg::RADIX) : raw[3:0];
      borrow_in = bout;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         borrow_ff <= 1'b0;
      end else if (ctl.step) begin
         borrow_ff <= borrow_in;
      end
   end

endmodule

// ----- sv/dsts_digit_store.sv -----
// dsts_digit_store: one BCD number held as a circular digit memory with a fill count.
// Read position 0 is the least significant digit. Depends on dsts_pkg.
module dsts_digit_store (
   input  logic                   clock,
   input  logic                   reset,
   input  dsts_pkg::store_ctl_type ctl,
   input  logic [3:0]             push_digit,
   output logic [3:0]             rd_digit
);

   logic [3:0] mem [dsts_pkg::DIGITS];

   logic [dsts_pkg::ADDR_W-1:0] wp_ff;
   logic [dsts_pkg::ADDR_W-1:0] wp_in;
   logic [dsts_pkg::CNT_W-1:0]  cnt_ff;
   logic [dsts_pkg::CNT_W-1:0]  cnt_in;
   logic                        rd_ok_ff;
   logic                        rd_ok_in;
   logic [3:0]                  rd_q_ff;

   logic [dsts_pkg::CNT_W-1:0]  pos_sum;
   logic [dsts_pkg::CNT_W-1:0]  pos_wrap;
   logic [dsts_pkg::ADDR_W-1:0] rd_addr;

   always_comb begin
      // newest digit sits at wp-1; walk downward modulo the depth
      pos_sum  = {1'b0, wp_ff} + dsts_pkg::POS_LAST - {1'b0, ctl.rd_pos};
      pos_wrap = pos_sum - dsts_pkg::CNT_FULL;
      rd_addr  = (pos_sum >= dsts_pkg::CNT_FULL) ? pos_wrap[dsts_pkg::ADDR_W-1:0]
                                                : pos_sum[dsts_pkg::ADDR_W-1:0];
      rd_ok_in = {1'b0, ctl.rd_pos} < cnt_ff;

      wp_in  = wp_ff;
      cnt_in = cnt_ff;
      if (ctl.clear) begin
         wp_in  = '0;
         cnt_in = '0;
      end else if (ctl.push) begin
         wp_in = (wp_ff == dsts_pkg::ADDR_LAST) ? '0 : wp_ff + 1'b1;
         if (cnt_ff != dsts_pkg::CNT_FULL) begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         cnt_ff   <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         wp_ff    <= wp_in;
         cnt_ff   <= cnt_in;
         rd_ok_ff <= rd_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[wp_ff] <= push_digit;
      end
      rd_q_ff <= mem[rd_addr];
   end

   // digits above the fill count read as zero
   assign rd_digit = rd_ok_ff ? rd_q_ff : 4'd0;

endmodule

// ----- tb/testbench.sv -----
// Self-checking bench for decimal_signed_triple_subtract_unit: digit loads, compute requests
// and signed BCD results, predicted in-bench and checked result by result.
// Depends on dsts_pkg and the unit's RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [dsts_pkg::DIGITS*4-1:0] bcd_word_type;

   typedef struct {
      logic       negative;
      logic [3:0] digit_res;
      logic       last;
   } result_digit_type;

   logic       clock;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;           // [3:0] digit, [7:4] zero
   logic [1:0] req_tuser  = dsts_pkg::CMD_X; // [1:0] cmd
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;                    // [3:0] digit_res, [7:4] zero
   logic       rsp_tuser;                    // [0] negative
   logic       rsp_tlast;

   bcd_word_type     x_num, y_num, z_num;
   result_digit_type expected_digits[$];
   bit               gaps_on   = 1'b1;
   bit               stalls_on = 1'b1;
   int               n_requests, n_computes, n_results, n_errors;
   int               stall_left;

   decimal_signed_triple_subtract_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- BCD arithmetic
   function automatic bcd_word_type bcd_sub(input bcd_word_type p, input bcd_word_type q);
      int           d;
      int           borrow;
      bcd_word_type r;
      borrow = 0;
      r      = '0;
      for (int k = 0; k < dsts_pkg::DIGITS; k++) begin
         d      = int'(p[k*4 +: 4]) - int'(q[k*4 +: 4]) - borrow;
         borrow = 0;
         if (d < 0) begin
            d      = d + 10;
            borrow = 1;
         end
         r[k*4 +: 4] = 4'(d);
      end
      return r;
   endfunction

   // carry out of the top digit is dropped
   function automatic bcd_word_type bcd_add(input bcd_word_type p, input bcd_word_type q);
      int           d;
      int           carry;
      bcd_word_type r;
      carry = 0;
      r     = '0;
      for (int k = 0; k < dsts_pkg::DIGITS; k++) begin
         d     = int'(p[k*4 +: 4]) + int'(q[k*4 +: 4]) + carry;
         carry = 0;
         if (d >= 10) begin
            d     = d - 10;
            carry = 1;
         end
         r[k*4 +: 4] = 4'(d);
      end
      return r;
   endfunction

   // Valid BCD orders the same as plain binary, so stores compare directly.
   task automatic apply_request(input dsts_pkg::cmd_type cmd, input logic [3:0] raw);
      logic [3:0]       dg;
      bcd_word_type     mag;
      logic             neg;
      int               top;
      result_digit_type rd;
      dg = (raw > 4'd9) ? 4'd9 : raw;
      case (cmd)
         dsts_pkg::CMD_X: x_num = {x_num[dsts_pkg::DIGITS*4-5:0], dg};
         dsts_pkg::CMD_Y: y_num = {y_num[dsts_pkg::DIGITS*4-5:0], dg};
         dsts_pkg::CMD_Z: z_num = {z_num[dsts_pkg::DIGITS*4-5:0], dg};
         default: begin
            if (y_num <= x_num) begin
               mag = bcd_sub(x_num, y_num);
               if (z_num <= mag) begin
                  mag = bcd_sub(mag, z_num);
                  neg = 1'b0;
               end else begin
                  mag = bcd_sub(z_num, mag);
                  neg = 1'b1;
               end
            end else begin
               mag = bcd_add(z_num, bcd_sub(y_num, x_num));
               neg = 1'b1;
            end
            top = dsts_pkg::DIGITS - 1;
            while (top > 0 && mag[top*4 +: 4] == 4'd0) top--;
            for (int k = top; k >= 0; k--) begin
               rd.negative  = neg;
               rd.digit_res = mag[k*4 +: 4];
               rd.last      = (k == 0);
               expected_digits.push_back(rd);
            end
            x_num = '0;
            y_num = '0;
            z_num = '0;
            n_computes++;
         end
      endcase
   endtask

   // ---------------------------------------------------------------- result side
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!stalls_on || $urandom_range(0, 3) != 0) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b0;
         stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      result_digit_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_results++;
         if (expected_digits.size() == 0) begin
            $error("unexpected result: digit_res %0d negative %0b last %0b",
                   rsp_tdata[3:0], rsp_tuser, rsp_tlast);
            n_errors++;
         end else begin
            e = expected_digits.pop_front();
            if (rsp_tuser !== e.negative) begin
               $error("negative: expected %0b, got %0b", e.negative, rsp_tuser);
               n_errors++;
            end
            if (rsp_tdata[3:0] !== e.digit_res) begin
               $error("digit_res: expected %0d, got %0d", e.digit_res, rsp_tdata[3:0]);
               n_errors++;
            end
            if (rsp_tlast !== e.last) begin
               $error("last: expected %0b, got %0b", e.last, rsp_tlast);
               n_errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- request side
   // Called at a rising edge; returns at a rising edge with req_tvalid possibly still high.
   task automatic send_request(input dsts_pkg::cmd_type cmd, input logic [3:0] dg);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'b0000, dg};
      do @(posedge clock); while (!req_tready);
      apply_request(cmd, dg);
      n_requests++;
      gap = gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_digits.size() != 0);
   endtask

   function automatic logic [3:0] rand_digit();
      if ($urandom_range(0, 9) < 8) return 4'($urandom_range(0, 9));
      return 4'($urandom_range(10, 15));
   endfunction

   task automatic send_int(input dsts_pkg::cmd_type cmd, input int v);
      int pow;
      pow = 1;
      while (pow * 10 <= v) pow = pow * 10;
      while (pow > 0) begin
         send_request(cmd, 4'((v / pow) % 10));
         pow = pow / 10;
      end
   endtask

   // operand digits in random interleaving across the three stores
   task automatic send_operands(input int nx, input int ny, input int nz);
      int left[3];
      int c;
      left = '{nx, ny, nz};
      while (left[0] + left[1] + left[2] > 0) begin
         c = $urandom_range(0, 2);
         if (left[c] > 0) begin
            send_request(dsts_pkg::cmd_type'(c), rand_digit());
            left[c]--;
         end
      end
   endtask

   task automatic compute();
      send_request(dsts_pkg::CMD_CALC, 4'($urandom_range(0, 15)));
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_empty_compute();
      compute();
      wait_drained();
   endtask

   task automatic test_sign_paths();
      send_int(dsts_pkg::CMD_X, 53); send_int(dsts_pkg::CMD_Y, 21);
      send_int(dsts_pkg::CMD_Z, 4);
      compute();                                   // positive
      send_int(dsts_pkg::CMD_X, 12); send_int(dsts_pkg::CMD_Y, 3);
      send_int(dsts_pkg::CMD_Z, 40);
      compute();                                   // z above x - y
      send_int(dsts_pkg::CMD_X, 5); send_int(dsts_pkg::CMD_Y, 70);
      send_int(dsts_pkg::CMD_Z, 9);
      compute();                                   // x below y
      send_int(dsts_pkg::CMD_X, 8); send_int(dsts_pkg::CMD_Y, 8);
      send_request(dsts_pkg::CMD_CALC, 4'hf);      // zero result
      wait_drained();
   endtask

   task automatic test_digit_clamp();
      send_request(dsts_pkg::CMD_X, 4'd15); send_request(dsts_pkg::CMD_X, 4'd10);
      send_request(dsts_pkg::CMD_Y, 4'd12);
      send_request(dsts_pkg::CMD_Z, 4'd11); send_request(dsts_pkg::CMD_Z, 4'd13);
      send_request(dsts_pkg::CMD_Z, 4'd14);
      compute();
      wait_drained();
   endtask

   task automatic test_store_overflow();
      send_operands(dsts_pkg::DIGITS + 2, 2, 1);
      compute();
      wait_drained();
   endtask

   // 0 - (10^DIGITS - 1) - 1 wraps to an all-zero magnitude that is still negative
   task automatic test_magnitude_wrap();
      gaps_on = 1'b0;
      repeat (dsts_pkg::DIGITS) send_request(dsts_pkg::CMD_Y, 4'd9);
      send_request(dsts_pkg::CMD_Z, 4'd1);
      compute();
      wait_drained();
      gaps_on = 1'b1;
   endtask

   task automatic test_random_sequences(input int target);
      while (n_requests < target) begin
         gaps_on   = ($urandom_range(0, 3) != 0);
         stalls_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 6) == 0) begin
            // noise: any command, any digit
            repeat ($urandom_range(1, 6))
               send_request(dsts_pkg::cmd_type'($urandom_range(0, 3)),
                            4'($urandom_range(0, 15)));
         end else begin
            send_operands($urandom_range(0, 7), $urandom_range(0, 7), $urandom_range(0, 7));
            compute();
         end
      end
      compute();
      wait_drained();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_empty_compute();
      test_sign_paths();
      test_digit_clamp();
      test_store_overflow();
      test_magnitude_wrap();
      test_random_sequences(260);
      stalls_on = 1'b0;
      repeat (400) @(posedge clock);
      $display("covered %0d requests, %0d compute requests, %0d result digits checked",
               n_requests, n_computes, n_results);
      $display("including clamped digits, store overflow and a wrapped negative magnitude");
      if (n_errors == 0 && expected_digits.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
